/* rtl/tsqg_pkg.sv */
package tsqg_pkg;

  localparam int MAX_TRAILS_DEF = 16;

  localparam int TRAIL_W   = 6;
  localparam int POS_W     = 24;
  localparam int SIDE_W    = 16;
  localparam int STR_W     = 16;
  localparam int PSTR_W    = 15;
  localparam int HW_W      = 16;
  localparam int GAIN_W    = 16;
  localparam int USE_W     = 5;
  localparam int ALPHA_W   = 8;
  localparam int DIFF_W    = POS_W + 1;
  localparam int SQ_W      = 48;
  localparam int DSQ_W     = SQ_W + 2;
  localparam int PROD_W    = SIDE_W + HW_W + 1;
  localparam int OFS_W     = PROD_W - 14;
  localparam int SAT_W     = POS_W + 2;
  localparam int GPROD_W   = PSTR_W + GAIN_W;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;

  localparam logic [PSTR_W-1:0] STR_ONE    = PSTR_W'(16384);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(4096);

  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'((1 << (POS_W - 1)) - 1);
  localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(-(1 << (POS_W - 1)));

  localparam logic CMD_EMIT = 1'b0;
  localparam logic CMD_CUT  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLIP_THRESHOLD,
    REG_MIN_SEG_LEN_SQ,
    REG_HALF_WIDTH_REAR,
    REG_HALF_WIDTH_FRONT,
    REG_ALPHA_GAIN,
    REG_TRAILS_IN_USE
  } cfg_reg_t;

  typedef struct packed {
    logic                     command;
    logic [TRAIL_W-1:0]       trail_index;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [SIDE_W-1:0] side_x;
    logic signed [SIDE_W-1:0] side_z;
    logic [STR_W-1:0]         strength;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] vert_x;
    logic signed [POS_W-1:0] vert_y;
    logic [ALPHA_W-1:0]      alpha;
    logic                    last;
  } out_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  prev_x;
    logic signed [POS_W-1:0]  prev_y;
    logic signed [POS_W-1:0]  prev_z;
    logic signed [SIDE_W-1:0] prev_side_x;
    logic signed [SIDE_W-1:0] prev_side_z;
    logic [PSTR_W-1:0]        prev_strength;
  } entry_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] z;
  } corner_t;

  typedef struct packed {
    corner_t            a_neg;
    corner_t            a_pos;
    corner_t            b_pos;
    corner_t            b_neg;
    logic [ALPHA_W-1:0] alpha_a;
    logic [ALPHA_W-1:0] alpha_b;
  } band_t;

  // strength clamped to one
  function automatic logic [PSTR_W-1:0] str_clamp(input logic [STR_W-1:0] s);
    if (s > STR_W'(STR_ONE)) return STR_ONE;
    else return s[PSTR_W-1:0];
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SAT_W-1:0] v);
    if (v > SAT_HI) return SAT_HI[POS_W-1:0];
    else if (v < SAT_LO) return SAT_LO[POS_W-1:0];
    else return $signed(v[POS_W-1:0]);
  endfunction

  // round to nearest, ties up, from Q.22 to Q.8
  function automatic logic signed [OFS_W-1:0] offset_round(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W:0] r;
    r = {p[PROD_W-1], p} + (PROD_W + 1)'(8192);
    return $signed(r[PROD_W-1:14]);
  endfunction

  function automatic logic [SQ_W-1:0] square(input logic signed [DIFF_W-1:0] d);
    logic signed [DSQ_W-1:0] p;
    p = DSQ_W'(d) * DSQ_W'(d);
    return p[SQ_W-1:0];
  endfunction

  // gain product to alpha byte: clamp at one, scale by 255, round
  function automatic logic [ALPHA_W-1:0] alpha_scale(input logic [GPROD_W-1:0] p);
    logic [26:0] pc;
    logic [34:0] sc;
    pc = (p > GPROD_W'(1 << 26)) ? 27'(1 << 26) : p[26:0];
    sc = {pc, 8'b0} - {8'b0, pc} + 35'(1 << 25);
    return sc[33:26];
  endfunction

endpackage

/* rtl/tsqg_store.sv */
module tsqg_store #(
  parameter int MAX_TRAILS = tsqg_pkg::MAX_TRAILS_DEF
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [$clog2(MAX_TRAILS)-1:0] rd_addr,
  output tsqg_pkg::entry_t              rd_data,
  input  logic                          wr_en,
  input  logic [$clog2(MAX_TRAILS)-1:0] wr_addr,
  input  tsqg_pkg::entry_t              wr_data
);

  // per trail last point, no reset: only read behind has_start
  tsqg_pkg::entry_t mem [MAX_TRAILS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/tsqg_band.sv */
module tsqg_band (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  tsqg_pkg::band_t     band,
  output logic                free,
  output logic                out_valid,
  input  logic                out_ready,
  output tsqg_pkg::out_item_t out_data
);

  localparam logic [2:0] VERT_LAST = 3'd5;

  logic            band_valid;
  logic [2:0]      cnt;
  tsqg_pkg::band_t band_q;
  tsqg_pkg::corner_t pick;
  logic [tsqg_pkg::ALPHA_W-1:0] pick_alpha;

  assign free      = !band_valid || (out_ready && cnt == VERT_LAST);
  assign out_valid = band_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      band_valid <= 1'b0;
      cnt        <= 3'd0;
    end else if (load) begin
      band_valid <= 1'b1;
      cnt        <= 3'd0;
    end else if (band_valid && out_ready) begin
      if (cnt == VERT_LAST) begin
        band_valid <= 1'b0;
      end else begin
        cnt <= cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      band_q <= band;
    end
  end

  // vertex order a-, a+, b+, a-, b+, b-
  always_comb begin
    unique case (cnt)
      3'd0: begin
        pick       = band_q.a_neg;
        pick_alpha = band_q.alpha_a;
      end
      3'd1: begin
        pick       = band_q.a_pos;
        pick_alpha = band_q.alpha_a;
      end
      3'd2: begin
        pick       = band_q.b_pos;
        pick_alpha = band_q.alpha_b;
      end
      3'd3: begin
        pick       = band_q.a_neg;
        pick_alpha = band_q.alpha_a;
      end
      3'd4: begin
        pick       = band_q.b_pos;
        pick_alpha = band_q.alpha_b;
      end
      default: begin
        pick       = band_q.b_neg;
        pick_alpha = band_q.alpha_b;
      end
    endcase
  end

  always_comb begin
    out_data.vert_x = pick.x;
    out_data.vert_y = pick.z;
    out_data.alpha  = pick_alpha;
    out_data.last   = (cnt == VERT_LAST);
  end

  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.last && !load |=> !out_valid)
    else $error("band stage still valid after its last vertex");

  a_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last && !load |=> out_valid && cnt == $past(cnt) + 3'd1)
    else $error("vertex counter did not step");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && !load |=> out_valid && $stable(cnt))
    else $error("vertex counter moved under stall");

endmodule

/* rtl/trail_segment_quad_generator.sv */
// trail segment quad generator
//
// in channel (in_valid/in_ready/in_data): one item per contact point or cut
// for one trail. out channel (out_valid/out_ready/out_data): vertices, six
// per band, the sixth flagged by last. cfg port: cfg_wr_en, cfg_addr,
// cfg_wdata; the user must write it only while the block is idle (unchecked).
//
// an item goes through four stages (memory read, products, squares and
// rounding, distance and corners) and its band is then loaded into the
// vertex stage once that stage is free. items that give no band flow at
// one per cycle while no band waits and no same-trail item is in flight;
// a band holds the vertex stage until its six vertices are taken, so
// banding items are limited by the single vertex output. an item for a
// trail that is still in one of the four stages waits until that item
// has written back, so the per-trail memory needs no forwarding.
//
// reset clears the per-trail start flags (flip-flops, no clearing pass)
// and loads the register defaults. a stalled receiver holds the vertex
// stage; once a band waits there, the stages behind it hold and in_ready
// drops.
module trail_segment_quad_generator #(
  parameter int MAX_TRAILS = tsqg_pkg::MAX_TRAILS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  tsqg_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output tsqg_pkg::out_item_t                out_data,
  input  logic                               cfg_wr_en,
  input  logic [tsqg_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [tsqg_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int AW = $clog2(MAX_TRAILS);

  // config registers
  logic [tsqg_pkg::STR_W-1:0]  cfg_slip;
  logic [tsqg_pkg::SQ_W-1:0]   cfg_minsq;
  logic [tsqg_pkg::HW_W-1:0]   cfg_hw_rear;
  logic [tsqg_pkg::HW_W-1:0]   cfg_hw_front;
  logic [tsqg_pkg::GAIN_W-1:0] cfg_gain;
  logic [tsqg_pkg::USE_W-1:0]  cfg_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_slip     <= '0;
      cfg_minsq    <= '0;
      cfg_hw_rear  <= '0;
      cfg_hw_front <= '0;
      cfg_gain     <= tsqg_pkg::GAIN_RESET;
      cfg_in_use   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        tsqg_pkg::REG_SLIP_THRESHOLD:   cfg_slip     <= cfg_wdata[tsqg_pkg::STR_W-1:0];
        tsqg_pkg::REG_MIN_SEG_LEN_SQ:   cfg_minsq    <= cfg_wdata[tsqg_pkg::SQ_W-1:0];
        tsqg_pkg::REG_HALF_WIDTH_REAR:  cfg_hw_rear  <= cfg_wdata[tsqg_pkg::HW_W-1:0];
        tsqg_pkg::REG_HALF_WIDTH_FRONT: cfg_hw_front <= cfg_wdata[tsqg_pkg::HW_W-1:0];
        tsqg_pkg::REG_ALPHA_GAIN:       cfg_gain     <= cfg_wdata[tsqg_pkg::GAIN_W-1:0];
        tsqg_pkg::REG_TRAILS_IN_USE:    cfg_in_use   <= cfg_wdata[tsqg_pkg::USE_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic adv;
  logic accept;
  logic hazard;
  logic in_range;
  logic [6:0] limit;
  logic [6:0] use_ext;

  logic s1_valid, s2_valid, s3_valid, s4_valid;
  tsqg_pkg::in_item_t s1_item, s2_item, s3_item, s4_item;
  logic s1_in_range, s2_in_range, s3_in_range, s4_in_range;
  logic s1_weak, s2_weak, s3_weak, s4_weak;

  // trails at or above min(trails_in_use, MAX_TRAILS) are ignored
  assign use_ext  = {2'b0, cfg_in_use};
  assign limit    = (use_ext < 7'(MAX_TRAILS)) ? use_ext : 7'(MAX_TRAILS);
  assign in_range = {1'b0, in_data.trail_index} < limit;

  // interlock: wait while the same trail is still in flight
  assign hazard =
      (s1_valid && s1_in_range && s1_item.trail_index == in_data.trail_index) ||
      (s2_valid && s2_in_range && s2_item.trail_index == in_data.trail_index) ||
      (s3_valid && s3_in_range && s3_item.trail_index == in_data.trail_index) ||
      (s4_valid && s4_in_range && s4_item.trail_index == in_data.trail_index);

  assign in_ready = adv && !hazard;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  // per-trail memory
  tsqg_pkg::entry_t rd_data;
  tsqg_pkg::entry_t wr_data;
  logic             wr_en;
  logic [AW-1:0]    s4_addr;

  tsqg_store #(
    .MAX_TRAILS (MAX_TRAILS)
  ) u_store (
    .clk     (clk),
    .rd_en   (accept && in_range),
    .rd_addr (in_data.trail_index[AW-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s4_addr),
    .wr_data (wr_data)
  );

  // stage 1: stored point arrives; differences and products
  logic [tsqg_pkg::HW_W-1:0]            s1_hw;
  logic signed [tsqg_pkg::DIFF_W-1:0]   s1_dx, s1_dy, s1_dz;
  logic signed [tsqg_pkg::PROD_W-1:0]   s1_pax, s1_paz, s1_pbx, s1_pbz;
  logic [tsqg_pkg::GPROD_W-1:0]         s1_ga, s1_gb;

  // index mod 4 of 2 or 3 is a front wheel
  assign s1_hw = s1_item.trail_index[1] ? cfg_hw_front : cfg_hw_rear;

  always_comb begin
    s1_dx  = tsqg_pkg::DIFF_W'(s1_item.pos_x) - tsqg_pkg::DIFF_W'(rd_data.prev_x);
    s1_dy  = tsqg_pkg::DIFF_W'(s1_item.pos_y) - tsqg_pkg::DIFF_W'(rd_data.prev_y);
    s1_dz  = tsqg_pkg::DIFF_W'(s1_item.pos_z) - tsqg_pkg::DIFF_W'(rd_data.prev_z);
    s1_pax = tsqg_pkg::PROD_W'(rd_data.prev_side_x) * tsqg_pkg::PROD_W'($signed({1'b0, s1_hw}));
    s1_paz = tsqg_pkg::PROD_W'(rd_data.prev_side_z) * tsqg_pkg::PROD_W'($signed({1'b0, s1_hw}));
    s1_pbx = tsqg_pkg::PROD_W'(s1_item.side_x) * tsqg_pkg::PROD_W'($signed({1'b0, s1_hw}));
    s1_pbz = tsqg_pkg::PROD_W'(s1_item.side_z) * tsqg_pkg::PROD_W'($signed({1'b0, s1_hw}));
    s1_ga  = tsqg_pkg::GPROD_W'(rd_data.prev_strength) * tsqg_pkg::GPROD_W'(cfg_gain);
    s1_gb  = tsqg_pkg::GPROD_W'(tsqg_pkg::str_clamp(s1_item.strength))
             * tsqg_pkg::GPROD_W'(cfg_gain);
  end

  logic signed [tsqg_pkg::POS_W-1:0]  s2_prev_x, s2_prev_z, s3_prev_x, s3_prev_z;
  logic signed [tsqg_pkg::DIFF_W-1:0] s2_dx, s2_dy, s2_dz;
  logic signed [tsqg_pkg::PROD_W-1:0] s2_pax, s2_paz, s2_pbx, s2_pbz;
  logic [tsqg_pkg::GPROD_W-1:0]       s2_ga, s2_gb;

  logic [tsqg_pkg::SQ_W-1:0]          s3_sqx, s3_sqy, s3_sqz;
  logic signed [tsqg_pkg::OFS_W-1:0]  s3_oax, s3_oaz, s3_obx, s3_obz;
  logic [tsqg_pkg::ALPHA_W-1:0]       s3_alpha_a, s3_alpha_b;

  logic [tsqg_pkg::DSQ_W-1:0]         s4_dsq;
  tsqg_pkg::band_t                    s4_band;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item     <= in_data;
      s1_in_range <= in_range;
      s1_weak     <= in_data.strength < cfg_slip;

      // stage 2
      s2_item     <= s1_item;
      s2_in_range <= s1_in_range;
      s2_weak     <= s1_weak;
      s2_prev_x   <= rd_data.prev_x;
      s2_prev_z   <= rd_data.prev_z;
      s2_dx       <= s1_dx;
      s2_dy       <= s1_dy;
      s2_dz       <= s1_dz;
      s2_pax      <= s1_pax;
      s2_paz      <= s1_paz;
      s2_pbx      <= s1_pbx;
      s2_pbz      <= s1_pbz;
      s2_ga       <= s1_ga;
      s2_gb       <= s1_gb;

      // stage 3: squares, offsets, alpha bytes
      s3_item     <= s2_item;
      s3_in_range <= s2_in_range;
      s3_weak     <= s2_weak;
      s3_prev_x   <= s2_prev_x;
      s3_prev_z   <= s2_prev_z;
      s3_sqx      <= tsqg_pkg::square(s2_dx);
      s3_sqy      <= tsqg_pkg::square(s2_dy);
      s3_sqz      <= tsqg_pkg::square(s2_dz);
      s3_oax      <= tsqg_pkg::offset_round(s2_pax);
      s3_oaz      <= tsqg_pkg::offset_round(s2_paz);
      s3_obx      <= tsqg_pkg::offset_round(s2_pbx);
      s3_obz      <= tsqg_pkg::offset_round(s2_pbz);
      s3_alpha_a  <= tsqg_pkg::alpha_scale(s2_ga);
      s3_alpha_b  <= tsqg_pkg::alpha_scale(s2_gb);

      // stage 4: squared distance and saturated band corners
      s4_item     <= s3_item;
      s4_in_range <= s3_in_range;
      s4_weak     <= s3_weak;
      s4_dsq      <= tsqg_pkg::DSQ_W'(s3_sqx) + tsqg_pkg::DSQ_W'(s3_sqy)
                     + tsqg_pkg::DSQ_W'(s3_sqz);
      s4_band.a_neg.x <= tsqg_pkg::sat_pos(tsqg_pkg::SAT_W'(s3_prev_x) - tsqg_pkg::SAT_W'(s3_oax));
      s4_band.a_neg.z <= tsqg_pkg::sat_pos(tsqg_pkg::SAT_W'(s3_prev_z) - tsqg_pkg::SAT_W'(s3_oaz));
      s4_band.a_pos.x <= tsqg_pkg::sat_pos(tsqg_pkg::SAT_W'(s3_prev_x) + tsqg_pkg::SAT_W'(s3_oax));
      s4_band.a_pos.z <= tsqg_pkg::sat_pos(tsqg_pkg::SAT_W'(s3_prev_z) + tsqg_pkg::SAT_W'(s3_oaz));
      s4_band.b_pos.x <= tsqg_pkg::sat_pos(tsqg_pkg::SAT_W'(s3_item.pos_x)
                                           + tsqg_pkg::SAT_W'(s3_obx));
      s4_band.b_pos.z <= tsqg_pkg::sat_pos(tsqg_pkg::SAT_W'(s3_item.pos_z)
                                           + tsqg_pkg::SAT_W'(s3_obz));
      s4_band.b_neg.x <= tsqg_pkg::sat_pos(tsqg_pkg::SAT_W'(s3_item.pos_x)
                                           - tsqg_pkg::SAT_W'(s3_obx));
      s4_band.b_neg.z <= tsqg_pkg::sat_pos(tsqg_pkg::SAT_W'(s3_item.pos_z)
                                           - tsqg_pkg::SAT_W'(s3_obz));
      s4_band.alpha_a <= s3_alpha_a;
      s4_band.alpha_b <= s3_alpha_b;
    end
  end

  // stage 4 decision and write-back
  logic [MAX_TRAILS-1:0] has_start;
  logic s4_act, s4_clear, s4_emit, s4_started, s4_far;
  logic band_go, store_go, band_free;

  assign s4_addr    = s4_item.trail_index[AW-1:0];
  assign s4_act     = s4_valid && s4_in_range;
  // cut command, or an emit too weak to mark, ends the trail
  assign s4_clear   = s4_act && (s4_item.command == tsqg_pkg::CMD_CUT || s4_weak);
  assign s4_emit    = s4_act && s4_item.command == tsqg_pkg::CMD_EMIT && !s4_weak;
  assign s4_started = s4_act && has_start[s4_addr];
  assign s4_far     = s4_dsq >= tsqg_pkg::DSQ_W'(cfg_minsq);
  assign band_go    = s4_emit && s4_started && s4_far;
  // first point of a trail is stored without a band; short segments are dropped
  assign store_go   = s4_emit && (!s4_started || s4_far);

  // the whole pipe holds only while a band waits for the vertex stage
  assign adv   = !band_go || band_free;
  assign wr_en = adv && store_go;

  always_comb begin
    wr_data.prev_x        = s4_item.pos_x;
    wr_data.prev_y        = s4_item.pos_y;
    wr_data.prev_z        = s4_item.pos_z;
    wr_data.prev_side_x   = s4_item.side_x;
    wr_data.prev_side_z   = s4_item.side_z;
    wr_data.prev_strength = tsqg_pkg::str_clamp(s4_item.strength);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      has_start <= '0;
    end else if (adv && s4_clear) begin
      has_start[s4_addr] <= 1'b0;
    end else if (adv && store_go) begin
      has_start[s4_addr] <= 1'b1;
    end
  end

  tsqg_band u_band (
    .clk       (clk),
    .rst       (rst),
    .load      (adv && band_go),
    .band      (s4_band),
    .free      (band_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_store_marks: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> has_start[$past(s4_addr)])
    else $error("stored point left its trail unstarted");

  a_band_holds: assert property (@(posedge clk) disable iff (rst)
    band_go && !band_free |=> s4_valid && $stable(s4_item.trail_index) && $stable(s4_band))
    else $error("waiting band lost while vertex stage busy");

  a_no_write_on_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |-> !wr_en && !in_ready)
    else $error("write-back or accept while pipe held");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import tsqg_pkg::*;

  localparam int NUM_TRAILS = MAX_TRAILS_DEF;
  localparam int POS_HI = 8388607;
  localparam int POS_LO = -8388608;
  localparam int SIDE_ONE = 16384;
  localparam int STR_FULL = 16384;

  // register indexes past the end of the list, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam logic [CFG_W-1:0] MINSQ_MAX = 48'hFFFF_FFFF_FFFF;

  // margins after the last acceptance, so items still in flight can finish
  localparam int IDLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 12;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 20000;
  localparam int PHASES = 5;
  localparam int ITEMS_PER_PHASE = 30;
  localparam int REPORT_MAX = 60;

  // how a stimulus row is checked
  typedef enum logic [1:0] {
    CHK_MODEL,  // vertices come from the band predictor
    CHK_NONE,   // typed in: item gives no vertex
    CHK_FLAT    // typed in: zero half width, band corners read off directly
  } chk_mode_e;

  typedef enum logic {
    ROW_ITEM,
    ROW_REG
  } row_kind_e;

  typedef struct {
    row_kind_e               kind;
    chk_mode_e               chk;
    logic [CFG_IDX_W-1:0]    reg_idx;
    logic [CFG_W-1:0]        reg_val;
    in_item_t                item;
    logic signed [POS_W-1:0] ax, az, bx, bz;
    logic [ALPHA_W-1:0]      aa, ba;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  trail_segment_quad_generator #(
    .MAX_TRAILS(NUM_TRAILS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // band predictor: own copy of registers and per-trail contact memory
  // ---------------------------------------------------------------------
  logic [STR_W-1:0]     cfg_slip = '0;
  logic [CFG_W-1:0]     cfg_minsq = '0;
  logic [HW_W-1:0]      cfg_hw_rear = '0;
  logic [HW_W-1:0]      cfg_hw_front = '0;
  logic [GAIN_W-1:0]    cfg_gain = GAIN_W'(4096);
  logic [USE_W-1:0]     cfg_in_use = '0;

  logic   started   [NUM_TRAILS];
  entry_t trail_mem [NUM_TRAILS];

  out_item_t band_buf [6];
  out_item_t pending_verts [$];

  dir_row_t dir_rows [$];

  int n_err = 0;
  int vert_seen = 0;
  int burst_left = 0;
  logic hold_req = 1'b0;

  initial begin
    for (int i = 0; i < NUM_TRAILS; i++) begin
      started[i] = 1'b0;
      trail_mem[i] = '0;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    n_err++;
    if (n_err <= REPORT_MAX)
      $display("vertex %0d %s: got %0d, expected %0d", vert_seen, what, got, want);
  endtask

  function automatic logic signed [POS_W-1:0] clip24(input longint v);
    if (v > POS_HI) return POS_W'(POS_HI);
    if (v < POS_LO) return POS_W'(POS_LO);
    return POS_W'(v);
  endfunction

  // side (Q1.14) times half width (Q8.8), rounded half up to Q.8
  function automatic longint side_offset(input logic signed [SIDE_W-1:0] s,
                                         input logic [HW_W-1:0] hw);
    longint p;
    p = longint'(s) * longint'({48'd0, hw}) + 64'sd8192;
    return p >>> 14;
  endfunction

  function automatic logic [ALPHA_W-1:0] strength_alpha(input logic [PSTR_W-1:0] s);
    longint unsigned p;
    p = longint'({49'd0, s}) * longint'({48'd0, cfg_gain});
    if (p > (64'd1 << 26)) p = 64'd1 << 26;
    return ALPHA_W'((p * 255 + (64'd1 << 25)) >> 26);
  endfunction

  function automatic void put_vert(input int k, input longint x, input longint z,
                                   input logic [ALPHA_W-1:0] a);
    band_buf[k].vert_x = clip24(x);
    band_buf[k].vert_y = clip24(z);
    band_buf[k].alpha  = a;
    band_buf[k].last   = (k == 5);
  endfunction

  // advances the trail memory by one item, returns the vertex count in band_buf
  function automatic int band_step(input in_item_t it);
    int unsigned t, lim;
    logic [PSTR_W-1:0] str;
    logic [HW_W-1:0] hw;
    longint dx, dy, dz, ax, az, bx, bz, oax, oaz, obx, obz;
    longint unsigned dsq;
    logic [ALPHA_W-1:0] ca, cb;
    int n;
    t = it.trail_index;
    lim = (cfg_in_use < NUM_TRAILS) ? cfg_in_use : NUM_TRAILS;
    n = 0;
    if (t >= lim) return 0;
    if (it.command == CMD_CUT) begin
      started[t] = 1'b0;
      return 0;
    end
    // weak contact ends the trail like a cut
    if (it.strength < cfg_slip) begin
      started[t] = 1'b0;
      return 0;
    end
    str = (it.strength > STR_W'(STR_FULL)) ? PSTR_W'(STR_FULL) : it.strength[PSTR_W-1:0];
    if (started[t]) begin
      ax = longint'($signed(trail_mem[t].prev_x));
      az = longint'($signed(trail_mem[t].prev_z));
      bx = longint'($signed(it.pos_x));
      bz = longint'($signed(it.pos_z));
      dx = bx - ax;
      dy = longint'($signed(it.pos_y)) - longint'($signed(trail_mem[t].prev_y));
      dz = bz - az;
      dsq = longint'(dx * dx + dy * dy + dz * dz);
      // too close: point dropped, memory untouched
      if (dsq < cfg_minsq) return 0;
      hw = ((t % 4) >= 2) ? cfg_hw_front : cfg_hw_rear;
      oax = side_offset(trail_mem[t].prev_side_x, hw);
      oaz = side_offset(trail_mem[t].prev_side_z, hw);
      obx = side_offset(it.side_x, hw);
      obz = side_offset(it.side_z, hw);
      ca = strength_alpha(trail_mem[t].prev_strength);
      cb = strength_alpha(str);
      put_vert(0, ax - oax, az - oaz, ca);
      put_vert(1, ax + oax, az + oaz, ca);
      put_vert(2, bx + obx, bz + obz, cb);
      put_vert(3, ax - oax, az - oaz, ca);
      put_vert(4, bx + obx, bz + obz, cb);
      put_vert(5, bx - obx, bz - obz, cb);
      n = 6;
    end
    trail_mem[t].prev_x        = it.pos_x;
    trail_mem[t].prev_y        = it.pos_y;
    trail_mem[t].prev_z        = it.pos_z;
    trail_mem[t].prev_side_x   = it.side_x;
    trail_mem[t].prev_side_z   = it.side_z;
    trail_mem[t].prev_strength = str;
    started[t] = 1'b1;
    return n;
  endfunction

  // ---------------------------------------------------------------------
  // directed table builders
  // ---------------------------------------------------------------------
  function automatic in_item_t pt(input logic cmd, input int t, input int x, input int y,
                                  input int z, input int sx, input int sz, input int st);
    in_item_t it;
    it.command     = cmd;
    it.trail_index = TRAIL_W'(t);
    it.pos_x       = POS_W'(x);
    it.pos_y       = POS_W'(y);
    it.pos_z       = POS_W'(z);
    it.side_x      = SIDE_W'(sx);
    it.side_z      = SIDE_W'(sz);
    it.strength    = STR_W'(st);
    return it;
  endfunction

  function automatic void add_item(input chk_mode_e chk, input in_item_t it);
    dir_row_t r;
    r.kind = ROW_ITEM;
    r.chk  = chk;
    r.item = it;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_flat(input in_item_t it, input int ax, input int az,
                                   input int aa, input int bx, input int bz, input int ba);
    dir_row_t r;
    r.kind = ROW_ITEM;
    r.chk  = CHK_FLAT;
    r.item = it;
    r.ax = POS_W'(ax);
    r.az = POS_W'(az);
    r.aa = ALPHA_W'(aa);
    r.bx = POS_W'(bx);
    r.bz = POS_W'(bz);
    r.ba = ALPHA_W'(ba);
    dir_rows.push_back(r);
  endfunction

  function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    dir_row_t r;
    r.kind    = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    dir_rows.push_back(r);
  endfunction

  // ---------------------------------------------------------------------
  // register writes, only with the block drained
  // ---------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    in_valid <= 1'b0;
    while (pending_verts.size() != 0) @(posedge clk);
    // items that give no vertex may still be in flight
    repeat (IDLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_SLIP_THRESHOLD:   cfg_slip     = val[STR_W-1:0];
      REG_MIN_SEG_LEN_SQ:   cfg_minsq    = val;
      REG_HALF_WIDTH_REAR:  cfg_hw_rear  = val[HW_W-1:0];
      REG_HALF_WIDTH_FRONT: cfg_hw_front = val[HW_W-1:0];
      REG_ALPHA_GAIN:       cfg_gain     = val[GAIN_W-1:0];
      REG_TRAILS_IN_USE:    cfg_in_use   = val[USE_W-1:0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------
  // sender: bursts of items with random gaps, expectations queued at accept
  // ---------------------------------------------------------------------
  task automatic send_row(input dir_row_t r);
    out_item_t va, vb;
    int n;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    in_data  <= r.item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    n = band_step(r.item);
    case (r.chk)
      CHK_MODEL: begin
        for (int k = 0; k < n; k++) pending_verts.push_back(band_buf[k]);
      end
      CHK_FLAT: begin
        // a-, a+, b+, a-, b+, b- with all offsets zero
        va.vert_x = r.ax;
        va.vert_y = r.az;
        va.alpha  = r.aa;
        va.last   = 1'b0;
        vb.vert_x = r.bx;
        vb.vert_y = r.bz;
        vb.alpha  = r.ba;
        vb.last   = 1'b0;
        pending_verts.push_back(va);
        pending_verts.push_back(va);
        pending_verts.push_back(vb);
        pending_verts.push_back(va);
        pending_verts.push_back(vb);
        vb.last = 1'b1;
        pending_verts.push_back(vb);
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------
  // random stimulus
  // ---------------------------------------------------------------------
  // mode 0 normal step, 1 short step, 2 anywhere, 3 near the saturation edges
  function automatic int rand_coord(input int prev, input int mode);
    longint v;
    case (mode)
      0: v = longint'(prev) + longint'($urandom_range(0, 8192)) - 4096;
      1: v = longint'(prev) + longint'($urandom_range(0, 256)) - 128;
      2: v = longint'(int'($urandom) >>> 8);
      default: begin
        if ($urandom_range(0, 1)) v = POS_HI - longint'($urandom_range(0, 70000));
        else v = POS_LO + longint'($urandom_range(0, 70000));
      end
    endcase
    if (v > POS_HI) v = POS_HI;
    if (v < POS_LO) v = POS_LO;
    return int'(v);
  endfunction

  function automatic int rand_side();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? SIDE_ONE : -SIDE_ONE;
    return int'($urandom_range(0, 2 * SIDE_ONE)) - SIDE_ONE;
  endfunction

  // mostly well formed contacts on live trails, plus cuts, strays and weak points
  function automatic in_item_t random_contact();
    in_item_t it;
    int unsigned lim, k;
    int mode, px, py, pz;
    lim = (cfg_in_use < NUM_TRAILS) ? cfg_in_use : NUM_TRAILS;
    it.command = ($urandom_range(0, 99) < 6) ? CMD_CUT : CMD_EMIT;
    if (lim == 0 || $urandom_range(0, 99) < 10) it.trail_index = TRAIL_W'($urandom_range(0, 63));
    else it.trail_index = TRAIL_W'($urandom_range(0, lim - 1));
    k = $urandom_range(0, 99);
    mode = (k < 70) ? 0 : (k < 82) ? 1 : (k < 92) ? 2 : 3;
    px = 0;
    py = 0;
    pz = 0;
    if (it.trail_index < NUM_TRAILS) begin
      px = int'($signed(trail_mem[it.trail_index].prev_x));
      py = int'($signed(trail_mem[it.trail_index].prev_y));
      pz = int'($signed(trail_mem[it.trail_index].prev_z));
    end
    it.pos_x  = POS_W'(rand_coord(px, mode));
    it.pos_y  = POS_W'(rand_coord(py, mode));
    it.pos_z  = POS_W'(rand_coord(pz, mode));
    it.side_x = SIDE_W'(rand_side());
    it.side_z = SIDE_W'(rand_side());
    if ($urandom_range(0, 99) < 85) it.strength = STR_W'($urandom_range(cfg_slip, 65535));
    else it.strength = STR_W'($urandom);
    return it;
  endfunction

  task automatic program_random_regs();
    int unsigned k;
    k = $urandom_range(0, 9);
    write_reg(REG_SLIP_THRESHOLD, (k < 3) ? '0 : (k == 9) ? CFG_W'(16'hFFFF) :
              CFG_W'($urandom_range(0, 20000)));
    k = $urandom_range(0, 9);
    write_reg(REG_MIN_SEG_LEN_SQ, (k < 2) ? '0 : (k == 9) ? MINSQ_MAX :
              CFG_W'($urandom_range(0, 1 << 22)));
    k = $urandom_range(0, 7);
    write_reg(REG_HALF_WIDTH_REAR, (k == 0) ? '0 : (k == 1) ? CFG_W'(16'hFFFF) :
              CFG_W'($urandom_range(0, 65535)));
    k = $urandom_range(0, 7);
    write_reg(REG_HALF_WIDTH_FRONT, (k == 0) ? '0 : (k == 1) ? CFG_W'(16'hFFFF) :
              CFG_W'($urandom_range(0, 65535)));
    k = $urandom_range(0, 7);
    write_reg(REG_ALPHA_GAIN, (k == 0) ? '0 : (k == 1) ? CFG_W'(4096) :
              (k == 2) ? CFG_W'(16'hFFFF) : CFG_W'($urandom_range(0, 65535)));
    k = $urandom_range(0, 9);
    write_reg(REG_TRAILS_IN_USE, (k < 7) ? CFG_W'(NUM_TRAILS) : CFG_W'($urandom_range(0, 16)));
    // a stray write past the list must leave everything alone
    if ($urandom_range(0, 1))
      write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, {$urandom, $urandom});
  endtask

  // ---------------------------------------------------------------------
  // receiver: segments of full speed, random and heavy stalls, plus one
  // long hold-off so the pipeline backs up into in_ready
  // ---------------------------------------------------------------------
  int rx_seg_left = 0;
  int rx_mode = 0;
  int rx_hold_left = 0;
  logic rx_hold_done = 1'b0;

  always @(posedge clk) begin
    if (hold_req && !rx_hold_done) begin
      rx_hold_done = 1'b1;
      rx_hold_left = HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (rx_seg_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_seg_left = $urandom_range(4, 40);
      end
      rx_seg_left--;
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // vertex checker: each accepted vertex against the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_verts.size() == 0) begin
        report_mismatch("with nothing expected, vert_x", longint'($signed(out_data.vert_x)), 0);
      end else begin
        want = pending_verts.pop_front();
        if (out_data.vert_x !== want.vert_x)
          report_mismatch("vert_x", longint'($signed(out_data.vert_x)),
                          longint'($signed(want.vert_x)));
        if (out_data.vert_y !== want.vert_y)
          report_mismatch("vert_y", longint'($signed(out_data.vert_y)),
                          longint'($signed(want.vert_y)));
        if (out_data.alpha !== want.alpha)
          report_mismatch("alpha", longint'(out_data.alpha), longint'(want.alpha));
        if (out_data.last !== want.last)
          report_mismatch("last", longint'(out_data.last), longint'(want.last));
      end
      vert_seen++;
    end
  end

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    dir_row_t row;
    int wait_cnt;

    // defaults after reset: no trail in use, everything ignored
    add_item(CHK_NONE, pt(CMD_EMIT, 0, 0, 0, 0, 0, 0, STR_FULL));
    add_item(CHK_NONE, pt(CMD_CUT, 63, 0, 0, 0, 0, 0, 0));

    // zero half width: band corners sit on the contact points
    add_reg(REG_SLIP_THRESHOLD, '0);
    add_reg(REG_MIN_SEG_LEN_SQ, '0);
    add_reg(REG_HALF_WIDTH_REAR, '0);
    add_reg(REG_HALF_WIDTH_FRONT, '0);
    add_reg(REG_ALPHA_GAIN, CFG_W'(4096));
    add_reg(REG_TRAILS_IN_USE, CFG_W'(NUM_TRAILS));
    add_item(CHK_NONE, pt(CMD_EMIT, 0, 0, 0, 0, 0, 0, STR_FULL));
    add_flat(pt(CMD_EMIT, 0, POS_HI, POS_HI, POS_HI, SIDE_ONE, SIDE_ONE, STR_FULL),
             0, 0, 255, POS_HI, POS_HI, 255);
    // strength above one clamps
    add_flat(pt(CMD_EMIT, 0, POS_LO, POS_LO, POS_LO, SIDE_ONE, -SIDE_ONE, 65535),
             POS_HI, POS_HI, 255, POS_LO, POS_LO, 255);
    // same point, zero length still passes a zero minimum, zero strength
    add_flat(pt(CMD_EMIT, 0, POS_LO, POS_LO, POS_LO, -SIDE_ONE, SIDE_ONE, 0),
             POS_LO, POS_LO, 255, POS_LO, POS_LO, 0);
    // cut, then the next point only restarts the trail
    add_item(CHK_NONE, pt(CMD_CUT, 0, 0, 0, 0, 0, 0, 0));
    add_item(CHK_NONE, pt(CMD_EMIT, 0, 5, 5, 5, 0, 0, STR_FULL));
    add_item(CHK_NONE, pt(CMD_EMIT, 15, 0, 0, 0, 0, 0, STR_FULL));
    // trail index at and beyond the allocated count
    add_item(CHK_NONE, pt(CMD_EMIT, 16, 0, 0, 0, 0, 0, STR_FULL));
    add_item(CHK_NONE, pt(CMD_EMIT, 63, POS_HI, POS_HI, POS_HI, -1, -1, 65535));

    // writes past the register list are dropped
    add_reg(REG_SPARE_A, MINSQ_MAX);
    add_reg(REG_SPARE_B, MINSQ_MAX);
    add_reg(REG_SLIP_THRESHOLD, CFG_W'(16'h2000));
    add_reg(REG_MIN_SEG_LEN_SQ, CFG_W'(1 << 20));
    add_reg(REG_HALF_WIDTH_REAR, CFG_W'(16'hFFFF));
    add_reg(REG_HALF_WIDTH_FRONT, CFG_W'(16'h0100));
    add_reg(REG_ALPHA_GAIN, CFG_W'(16'hFFFF));
    add_reg(REG_TRAILS_IN_USE, CFG_W'(5));
    // front trail near the top edge, offsets saturate
    add_item(CHK_MODEL, pt(CMD_EMIT, 2, POS_HI - 100, 0, POS_HI - 100, SIDE_ONE, SIDE_ONE, 16'h4000));
    add_item(CHK_MODEL, pt(CMD_EMIT, 2, POS_HI, 4096, POS_HI, -SIDE_ONE, SIDE_ONE, 16'h3000));
    // rear trail at the bottom edge, strength exactly at threshold
    add_item(CHK_MODEL, pt(CMD_EMIT, 1, POS_LO, 0, POS_LO, SIDE_ONE, -SIDE_ONE, 16'h2000));
    add_item(CHK_MODEL, pt(CMD_EMIT, 1, POS_LO + 2000, 0, POS_LO + 100, -SIDE_ONE, 0, 16'hFFFF));
    // short segment dropped, then a weak point cuts
    add_item(CHK_MODEL, pt(CMD_EMIT, 1, POS_LO + 2010, 0, POS_LO + 100, 0, SIDE_ONE, 16'h8000));
    add_item(CHK_MODEL, pt(CMD_EMIT, 1, 0, 0, 0, 0, 0, 16'h1FFF));
    add_item(CHK_MODEL, pt(CMD_EMIT, 1, 0, 0, 0, 1, -1, 16'h3000));
    add_item(CHK_MODEL, pt(CMD_EMIT, 4, 100, 100, 100, 0, 0, 16'h4000));
    add_item(CHK_MODEL, pt(CMD_EMIT, 5, 100, 100, 100, 0, 0, 16'h4000));

    // largest minimum length and threshold
    add_reg(REG_MIN_SEG_LEN_SQ, MINSQ_MAX);
    add_reg(REG_SLIP_THRESHOLD, CFG_W'(16'hFFFF));
    add_reg(REG_TRAILS_IN_USE, CFG_W'(NUM_TRAILS));
    add_item(CHK_MODEL, pt(CMD_EMIT, 3, POS_LO, POS_LO, POS_LO, SIDE_ONE, 0, 16'hFFFF));
    add_item(CHK_MODEL, pt(CMD_EMIT, 3, POS_HI, POS_HI, POS_HI, 0, SIDE_ONE, 16'hFFFF));
    add_item(CHK_MODEL, pt(CMD_EMIT, 3, 0, 0, 0, 0, 0, 16'hFFFF));
    add_item(CHK_MODEL, pt(CMD_EMIT, 3, 0, 0, 0, 0, 0, 16'hFFFE));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      else send_row(dir_rows[i]);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      program_random_regs();
      // long receiver hold-off while the sender keeps offering items
      if (phase == 1) hold_req <= 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        row.kind = ROW_ITEM;
        row.chk  = CHK_MODEL;
        row.item = random_contact();
        send_row(row);
      end
    end
    in_valid <= 1'b0;

    // drain, bounded
    for (wait_cnt = 0; pending_verts.size() != 0 && wait_cnt < DRAIN_LIMIT; wait_cnt++)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_verts.size() != 0)
      report_mismatch("missing, vertices still expected", 0, pending_verts.size());

    if (n_err == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
